// File: design/hu8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hu8_pkg
// Shared types and codes for the hex / UTF-8 validator with Latin-1 folding.
// ----------------------------------------------------------------------------
package hu8_pkg;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_BYTE,
    TK_PASS,
    TK_VSTART,
    TK_ERR
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  data;
    logic [2:0]  err;
    logic        held;
    logic        last;
  } tok_t;

  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_BAD_HEX = 3'd1;
  localparam logic [2:0] STATUS_ODD     = 3'd2;
  localparam logic [2:0] STATUS_BAD_UTF = 3'd3;
  localparam logic [2:0] STATUS_OPEN    = 3'd4;

endpackage

// File: design/hex_utf8_validate_latin1_fold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_utf8_validate_latin1_fold_core
// Hex-pair decoder with UTF-8 validation and Latin-1 folding of C2/C3 pairs.
// ----------------------------------------------------------------------------
// The block takes one character per cycle and sustains that rate for as long
// as results are taken. An accepted character is classified at once and
// enters a token queue of QUEUE_DEPTH entries; the sequence checker takes one
// token per cycle from it while the result register is free or being taken
// and loads the result register, so each result passes a queue entry and
// then the result register. While both sides flow the queue holds one token.
// When the result register is held by out_ready low, the checker stops
// taking tokens, the queue fills and in_ready falls once QUEUE_DEPTH tokens
// wait. Characters that produce no result (the first digit of a pair, a held
// C2 or C3, anything after an error) still pass through the checker.
module hex_utf8_validate_latin1_fold_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       verbatim,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       done_res,
  output logic [2:0] status
);
  import hu8_pkg::*;

  logic q_full;
  logic push;
  tok_t push_tok;
  logic q_valid;
  logic pop;
  tok_t pop_tok;

  hu8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .verbatim (verbatim),
    .last     (last),
    .q_full   (q_full),
    .push     (push),
    .tok      (push_tok)
  );

  hu8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_tok),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_tok)
  );

  hu8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (q_valid),
    .tok        (pop_tok),
    .tok_pop    (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .done_res   (done_res),
    .status     (status)
  );

  a_status_on_done_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == STATUS_OK)
    else $error("non-final result carries an error status");

  a_no_byte_with_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_OK |-> !byte_valid)
    else $error("byte delivered alongside an error status");

  a_empty_result_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> done_res && out_byte == 8'd0)
    else $error("result without byte is not the final one");

  a_stall_fills_queue: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid && (out_valid || !pop))
    else $error("input stalled while checker has nothing to wait for");

endmodule

// File: design/hu8_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hu8_front
// Accepts characters, pairs hex digits into bytes and classifies each
// character into a token for the sequence checker.
// ----------------------------------------------------------------------------
module hu8_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    ch,
  input  logic          verbatim,
  input  logic          last,
  input  logic          q_full,
  output logic          push,
  output hu8_pkg::tok_t tok
);
  import hu8_pkg::*;

  localparam logic [7:0] CH_AT = 8'h40;

  logic [3:0] high_nibble;
  logic       half_pair;
  logic       in_suffix;
  logic [3:0] high_nibble_next;
  logic       half_pair_next;
  logic       in_suffix_next;
  logic [4:0] hv;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
        t = c - 8'd48;
        hex_value = {1'b0, t[3:0]};
      end else if (c >= 8'd65 && c <= 8'd70) begin
        t = c - 8'd55;
        hex_value = {1'b0, t[3:0]};
      end else if (c >= 8'd97 && c <= 8'd102) begin
        t = c - 8'd87;
        hex_value = {1'b0, t[3:0]};
      end else begin
        hex_value = 5'd16;
      end
    end
  endfunction

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign hv       = hex_value(ch);

  always_comb begin
    high_nibble_next = high_nibble;
    half_pair_next   = half_pair;
    in_suffix_next   = in_suffix;
    tok.kind = TK_DIGIT;
    tok.data = ch;
    tok.err  = STATUS_OK;
    if (verbatim) begin
      in_suffix_next = 1'b1;
      if (in_suffix) begin
        tok.kind = TK_PASS;
      end else if (half_pair) begin
        tok.kind = TK_ERR;
        tok.err  = STATUS_ODD;
      end else begin
        tok.kind = TK_VSTART;
      end
    end else begin
      in_suffix_next = 1'b0;
      if (!half_pair && ch == CH_AT) begin
        tok.kind = TK_PASS;
      end else if (hv[4]) begin
        tok.kind = TK_ERR;
        tok.err  = STATUS_BAD_HEX;
      end else if (!half_pair) begin
        tok.kind         = TK_DIGIT;
        high_nibble_next = hv[3:0];
        half_pair_next   = 1'b1;
      end else begin
        tok.kind       = TK_BYTE;
        tok.data       = {high_nibble, hv[3:0]};
        half_pair_next = 1'b0;
      end
    end
    tok.held = half_pair_next;
    tok.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_nibble <= 4'd0;
      half_pair   <= 1'b0;
      in_suffix   <= 1'b0;
    end else if (push) begin
      if (last) begin
        high_nibble <= 4'd0;
        half_pair   <= 1'b0;
        in_suffix   <= 1'b0;
      end else begin
        high_nibble <= high_nibble_next;
        half_pair   <= half_pair_next;
        in_suffix   <= in_suffix_next;
      end
    end
  end

endmodule

// File: design/hu8_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hu8_queue
// Small token queue between the classifier and the sequence checker.
// ----------------------------------------------------------------------------
module hu8_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hu8_pkg::tok_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output hu8_pkg::tok_t pop_data
);
  import hu8_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tok_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_CNT);
  assign q_valid  = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/hu8_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hu8_back
// UTF-8 sequence checker with Latin-1 folding, sticky error and result
// register.
// ----------------------------------------------------------------------------
module hu8_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          tok_valid,
  input  hu8_pkg::tok_t tok,
  output logic          tok_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic          done_res,
  output logic [2:0]    status
);
  import hu8_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_C2, S_C3, S_ONE, S_E0, S_E1, S_ED, S_F0, S_TWO, S_F1, S_F4
  } seq_t;

  seq_t       seq_state;
  logic [2:0] error_code;

  seq_t       seq_next;
  logic [2:0] error_next;
  logic       emit;
  logic [7:0] byte_out;

  seq_t       feed_seq;
  logic       feed_ok;
  logic       feed_out;
  logic [7:0] feed_byte;
  logic       cont;
  logic [7:0] b;

  assign tok_pop = tok_valid && (!out_valid || out_ready);
  assign b       = tok.data;
  assign cont    = (b >= 8'h80 && b <= 8'hBF);

  always_comb begin
    feed_seq  = S_IDLE;
    feed_ok   = 1'b1;
    feed_out  = 1'b1;
    feed_byte = b;
    case (seq_state)
      S_IDLE: begin
        if (b < 8'h80) feed_seq = S_IDLE;
        else if (b == 8'hC2) begin
          feed_seq = S_C2;
          feed_out = 1'b0;
        end else if (b == 8'hC3) begin
          feed_seq = S_C3;
          feed_out = 1'b0;
        end else if (b >= 8'hC4 && b <= 8'hDF) feed_seq = S_ONE;
        else if (b == 8'hE0) feed_seq = S_E0;
        else if (b == 8'hED) feed_seq = S_ED;
        else if (b >= 8'hE1 && b <= 8'hEF) feed_seq = S_E1;
        else if (b == 8'hF0) feed_seq = S_F0;
        else if (b >= 8'hF1 && b <= 8'hF3) feed_seq = S_F1;
        else if (b == 8'hF4) feed_seq = S_F4;
        else feed_ok = 1'b0;
      end
      S_C2: begin
        feed_ok = cont;
      end
      S_C3: begin
        feed_ok   = cont;
        feed_byte = b + 8'h40;
      end
      S_ONE: begin
        feed_ok = cont;
      end
      S_E0: begin
        feed_ok  = (b >= 8'hA0 && b <= 8'hBF);
        feed_seq = S_ONE;
      end
      S_E1: begin
        feed_ok  = cont;
        feed_seq = S_ONE;
      end
      S_ED: begin
        feed_ok  = (b >= 8'h80 && b <= 8'h9F);
        feed_seq = S_ONE;
      end
      S_F0: begin
        feed_ok  = (b >= 8'h90 && b <= 8'hBF);
        feed_seq = S_TWO;
      end
      S_TWO: begin
        feed_ok  = cont;
        feed_seq = S_ONE;
      end
      S_F1: begin
        feed_ok  = cont;
        feed_seq = S_TWO;
      end
      S_F4: begin
        feed_ok  = (b >= 8'h80 && b <= 8'h8F);
        feed_seq = S_TWO;
      end
      default: begin
        feed_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    seq_next   = seq_state;
    error_next = error_code;
    emit       = 1'b0;
    byte_out   = tok.data;
    if (error_code == STATUS_OK) begin
      case (tok.kind)
        TK_DIGIT: begin
        end
        TK_BYTE: begin
          if (!feed_ok) begin
            error_next = STATUS_BAD_UTF;
          end else begin
            seq_next = feed_seq;
            emit     = feed_out;
            byte_out = feed_byte;
          end
        end
        TK_PASS: begin
          emit = 1'b1;
        end
        TK_VSTART: begin
          if (seq_state != S_IDLE) error_next = STATUS_OPEN;
          else emit = 1'b1;
        end
        TK_ERR: begin
          error_next = tok.err;
        end
        default: begin
        end
      endcase
      if (tok.last && error_next == STATUS_OK) begin
        if (tok.held) error_next = STATUS_ODD;
        else if (seq_next != S_IDLE) error_next = STATUS_OPEN;
      end
    end
    if (error_next != STATUS_OK) emit = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state  <= S_IDLE;
      error_code <= STATUS_OK;
      out_valid  <= 1'b0;
      out_byte   <= 8'd0;
      byte_valid <= 1'b0;
      done_res   <= 1'b0;
      status     <= STATUS_OK;
    end else begin
      if (tok_pop) begin
        if (tok.last) begin
          seq_state  <= S_IDLE;
          error_code <= STATUS_OK;
        end else begin
          seq_state  <= seq_next;
          error_code <= error_next;
        end
      end
      if (tok_pop && (tok.last || emit)) begin
        out_valid  <= 1'b1;
        out_byte   <= emit ? byte_out : 8'd0;
        byte_valid <= emit;
        done_res   <= tok.last;
        status     <= tok.last ? error_next : STATUS_OK;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: dv/hex_utf8_validate_latin1_fold_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_utf8_validate_latin1_fold_core_tb
// Self-checking bench for the hex / UTF-8 validator with Latin-1 folding.
// Strings of hex pairs, '@' markers and verbatim suffixes go in one character
// per transfer; a model of the decoder inside the bench predicts each result,
// and every result transfer is checked field by field against the oldest
// prediction. Directed strings cover folding, pass-through and each error
// status; random strings, mostly well-formed UTF-8, some broken, follow.
// Both sides stall at random.
// ----------------------------------------------------------------------------
module hex_utf8_validate_latin1_fold_core_tb;
  import hu8_pkg::*;

  localparam logic [7:0] CH_AT = 8'h40;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_C2, SQ_C3, SQ_ONE, SQ_E0, SQ_E1, SQ_ED, SQ_F0, SQ_TWO, SQ_F1, SQ_F4
  } utf_seq_t;

  typedef struct packed {
    logic [7:0] val;
    logic       has_byte;
    logic       done;
    logic [2:0] st;
  } fold_res_t;

  typedef struct packed {
    logic [7:0] c;
    logic       v;
  } text_char_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] ch;
  logic       verbatim;
  logic       last;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       done_res;
  logic [2:0] status;

  // decoder state of the prediction
  logic [3:0] hi_nib;
  logic       pair_open;
  utf_seq_t   seq_st;
  logic [2:0] err_code;
  logic       suffix_on;

  fold_res_t  folded_q[$];
  text_char_t line_q[$];

  int n_items, n_results, n_bytes, n_strings, n_fail, stall_left;
  int status_cnt[5];
  bit src_idle, sink_idle;

  hex_utf8_validate_latin1_fold_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .verbatim  (verbatim),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .done_res  (done_res),
    .status    (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic in_span(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
    return b >= lo && b <= hi;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (in_span(c, 8'h30, 8'h39)) return 5'(c - 8'h30);
    if (in_span(c, 8'h41, 8'h46)) return 5'(c - 8'h37);
    if (in_span(c, 8'h61, 8'h66)) return 5'(c - 8'h57);
    return 5'h10;
  endfunction

  // step the UTF-8 sequence checker; returns 1 when a byte goes out
  function automatic logic utf8_advance(input logic [7:0] b, output logic [7:0] b_out);
    utf_seq_t nxt;
    logic good, send;
    good = 1'b1;
    send = 1'b1;
    nxt = SQ_IDLE;
    b_out = b;
    case (seq_st)
      SQ_IDLE: begin
        if (b < 8'h80) nxt = SQ_IDLE;
        else if (b == 8'hC2) begin
          nxt = SQ_C2;
          send = 1'b0;
        end else if (b == 8'hC3) begin
          nxt = SQ_C3;
          send = 1'b0;
        end else if (in_span(b, 8'hC4, 8'hDF)) nxt = SQ_ONE;
        else if (b == 8'hE0) nxt = SQ_E0;
        else if (b == 8'hED) nxt = SQ_ED;
        else if (in_span(b, 8'hE1, 8'hEF)) nxt = SQ_E1;
        else if (b == 8'hF0) nxt = SQ_F0;
        else if (in_span(b, 8'hF1, 8'hF3)) nxt = SQ_F1;
        else if (b == 8'hF4) nxt = SQ_F4;
        else good = 1'b0;
      end
      SQ_C2:  if (in_span(b, 8'h80, 8'hBF)) nxt = SQ_IDLE; else good = 1'b0;
      SQ_C3: begin
        if (in_span(b, 8'h80, 8'hBF)) begin
          nxt = SQ_IDLE;
          b_out = b + 8'h40;
        end else good = 1'b0;
      end
      SQ_ONE: if (in_span(b, 8'h80, 8'hBF)) nxt = SQ_IDLE; else good = 1'b0;
      SQ_E0:  if (in_span(b, 8'hA0, 8'hBF)) nxt = SQ_ONE; else good = 1'b0;
      SQ_E1:  if (in_span(b, 8'h80, 8'hBF)) nxt = SQ_ONE; else good = 1'b0;
      SQ_ED:  if (in_span(b, 8'h80, 8'h9F)) nxt = SQ_ONE; else good = 1'b0;
      SQ_F0:  if (in_span(b, 8'h90, 8'hBF)) nxt = SQ_TWO; else good = 1'b0;
      SQ_TWO: if (in_span(b, 8'h80, 8'hBF)) nxt = SQ_ONE; else good = 1'b0;
      SQ_F1:  if (in_span(b, 8'h80, 8'hBF)) nxt = SQ_TWO; else good = 1'b0;
      SQ_F4:  if (in_span(b, 8'h80, 8'h8F)) nxt = SQ_TWO; else good = 1'b0;
      default: good = 1'b0;
    endcase
    if (!good) begin
      err_code = STATUS_BAD_UTF;
      return 1'b0;
    end
    seq_st = nxt;
    return send;
  endfunction

  function automatic void clear_decoder();
    hi_nib = '0;
    pair_open = 1'b0;
    seq_st = SQ_IDLE;
    err_code = STATUS_OK;
    suffix_on = 1'b0;
  endfunction

  // predict the result of one accepted character
  function automatic void fold_char(logic [7:0] c, logic v, logic l);
    logic emit;
    logic [7:0] val;
    logic [4:0] d;
    emit = 1'b0;
    val = '0;
    n_items++;
    if (err_code == STATUS_OK) begin
      if (v) begin
        if (!suffix_on) begin
          if (pair_open) err_code = STATUS_ODD;
          else if (seq_st != SQ_IDLE) err_code = STATUS_OPEN;
          suffix_on = 1'b1;
        end
        if (err_code == STATUS_OK) begin
          emit = 1'b1;
          val = c;
        end
      end else begin
        suffix_on = 1'b0;
        if (!pair_open && c == CH_AT) begin
          emit = 1'b1;
          val = c;
        end else begin
          d = hex_digit(c);
          if (d[4]) err_code = STATUS_BAD_HEX;
          else if (!pair_open) begin
            hi_nib = d[3:0];
            pair_open = 1'b1;
          end else begin
            pair_open = 1'b0;
            emit = utf8_advance({hi_nib, d[3:0]}, val);
          end
        end
      end
      if (l && err_code == STATUS_OK) begin
        if (pair_open) err_code = STATUS_ODD;
        else if (seq_st != SQ_IDLE) err_code = STATUS_OPEN;
      end
    end
    if (err_code != STATUS_OK) emit = 1'b0;
    if (emit) n_bytes++;
    if (l) begin
      folded_q.push_back({emit ? val : 8'h00, emit, 1'b1, err_code});
      status_cnt[err_code]++;
      n_strings++;
      clear_decoder();
    end else if (emit) begin
      folded_q.push_back({val, 1'b1, 1'b0, STATUS_OK});
    end
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : result_mon
    fold_res_t e;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      n_results++;
      if (folded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %0h status %0d",
                 $time, out_byte, status);
        n_fail++;
      end else begin
        e = folded_q.pop_front();
        check_field("out_byte", e.val, out_byte);
        check_field("byte_valid", 8'(e.has_byte), 8'(byte_valid));
        check_field("done_res", 8'(e.done), 8'(done_res));
        check_field("status", 8'(e.st), 8'(status));
      end
    end
  end

  always @(negedge clk) begin : sink_drv
    int g;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      g = sink_idle ? idle_len() : 0;
      if (g > 0) begin
        stall_left = g - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_char(logic [7:0] c, logic v, logic l);
    int gap;
    gap = src_idle ? idle_len() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    ch = c;
    verbatim = v;
    last = l;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    fold_char(c, v, l);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i].c, line_q[i].v, i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (folded_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] rand_span(logic [7:0] lo, logic [7:0] hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic void add_char(logic [7:0] c, logic v);
    line_q.push_back({c, v});
  endfunction

  function automatic void add_hex(logic [7:0] b);
    add_char(hex_char(b[7:4]), 1'b0);
    add_char(hex_char(b[3:0]), 1'b0);
  endfunction

  function automatic void add_cont(logic [7:0] lo, logic [7:0] hi);
    if ($urandom_range(0, 7) == 0) add_char(CH_AT, 1'b0);
    add_hex(rand_span(lo, hi));
  endfunction

  // append one complete, well-formed piece
  function automatic void add_seq();
    logic [7:0] lead;
    case ($urandom_range(0, 9))
      0, 1: add_hex(rand_span(8'h00, 8'h7F));
      2: add_char(CH_AT, 1'b0);
      3: begin
        case ($urandom_range(0, 2))
          0: lead = 8'hC2;
          1: lead = 8'hC3;
          default: lead = rand_span(8'hC4, 8'hDF);
        endcase
        add_hex(lead);
        add_cont(8'h80, 8'hBF);
      end
      4: begin
        add_hex(8'hE0);
        add_cont(8'hA0, 8'hBF);
        add_cont(8'h80, 8'hBF);
      end
      5: begin
        add_hex(8'hED);
        add_cont(8'h80, 8'h9F);
        add_cont(8'h80, 8'hBF);
      end
      6: begin
        lead = rand_span(8'hE1, 8'hEF);
        add_hex(lead == 8'hED ? 8'hEE : lead);
        add_cont(8'h80, 8'hBF);
        add_cont(8'h80, 8'hBF);
      end
      7: begin
        add_hex(8'hF0);
        add_cont(8'h90, 8'hBF);
        add_cont(8'h80, 8'hBF);
        add_cont(8'h80, 8'hBF);
      end
      8: begin
        add_hex(rand_span(8'hF1, 8'hF3));
        repeat (3) add_cont(8'h80, 8'hBF);
      end
      default: begin
        add_hex(8'hF4);
        add_cont(8'h80, 8'h8F);
        add_cont(8'h80, 8'hBF);
        add_cont(8'h80, 8'hBF);
      end
    endcase
  endfunction

  function automatic void add_verbatim(int n);
    repeat (n) add_char(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void build_clean();
    repeat ($urandom_range(1, 5)) begin
      add_seq();
      if ($urandom_range(0, 9) == 0) add_verbatim($urandom_range(1, 3));
    end
    if ($urandom_range(0, 2) == 0) add_verbatim($urandom_range(1, 4));
  endfunction

  function automatic void break_line();
    int idx;
    idx = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 5))
      0: line_q[idx].c = 8'($urandom_range(0, 255));
      1: if (line_q.size() > 1) line_q.delete(idx);
         else line_q[0].c = 8'($urandom_range(0, 255));
      2: begin
        add_hex(rand_span(8'hC2, 8'hF4));
        if ($urandom_range(0, 1)) add_verbatim(1);
      end
      3: begin
        case ($urandom_range(0, 6))
          0: begin add_hex(8'hE0); add_hex(rand_span(8'h80, 8'h9F)); end
          1: begin add_hex(8'hED); add_hex(rand_span(8'hA0, 8'hBF)); end
          2: begin add_hex(8'hF0); add_hex(rand_span(8'h80, 8'h8F)); end
          3: begin add_hex(8'hF4); add_hex(rand_span(8'h90, 8'hBF)); end
          4: add_hex(rand_span(8'hC0, 8'hC1));
          5: add_hex(rand_span(8'hF5, 8'hFF));
          default: add_hex(rand_span(8'h80, 8'hBF));
        endcase
        if ($urandom_range(0, 1)) add_seq();
      end
      4: begin
        add_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        add_char(CH_AT, 1'b0);
        add_seq();
      end
      default: begin
        add_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
        if ($urandom_range(0, 1)) add_verbatim(1);
      end
    endcase
  endfunction

  task automatic test_latin1_fold();
    // C3 BF folds to FF
    add_hex(8'hC3);
    add_hex(8'hBF);
    send_line();
  endtask

  task automatic test_at_passthrough();
    // '@' inside a held C2, then a verbatim suffix ending in FF
    add_hex(8'hC2);
    add_char(CH_AT, 1'b0);
    add_hex(8'h80);
    add_char(CH_AT, 1'b1);
    add_char(8'hFF, 1'b1);
    send_line();
  endtask

  task automatic test_bad_hex();
    // '@' in place of a second digit
    add_char(8'h34, 1'b0);
    add_char(CH_AT, 1'b0);
    add_char(8'h31, 1'b0);
    send_line();
  endtask

  task automatic test_odd_count();
    add_char(8'h61, 1'b0);
    send_line();
    // held digit at the start of the suffix
    add_char(8'h37, 1'b0);
    add_char(8'h7A, 1'b1);
    send_line();
  endtask

  task automatic test_open_sequence();
    // F4 8F leaves two continuations due when the suffix starts
    add_hex(8'hF4);
    add_hex(8'h8F);
    add_char(8'h71, 1'b1);
    send_line();
  endtask

  task automatic test_utf8_limit();
    add_hex(8'hED);
    add_hex(8'hA0);
    send_line();
  endtask

  task automatic test_back_from_suffix();
    add_char(8'h61, 1'b1);
    add_hex(8'h41);
    send_line();
  endtask

  task automatic test_random_strings(int n_target);
    int goal, lines;
    goal = n_items + n_target;
    lines = 0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    while (n_items < goal) begin
      if (lines % 30 == 29) begin
        // hold off until every outstanding result has arrived
        drain_results();
        src_idle = $urandom_range(0, 2) != 0;
        sink_idle = $urandom_range(0, 2) != 0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: build_clean();
        6, 7, 8: begin
          build_clean();
          break_line();
        end
        default: begin
          repeat ($urandom_range(1, 8))
            add_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      endcase
      send_line();
      lines++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    ch = '0;
    verbatim = 1'b0;
    last = 1'b0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    clear_decoder();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_latin1_fold();
    test_at_passthrough();
    test_bad_hex();
    test_odd_count();
    test_open_sequence();
    test_utf8_limit();
    test_back_from_suffix();
    test_random_strings(1600);

    drain_results();
    repeat (10) @(posedge clk);

    $display("%0d characters in %0d strings, %0d results, %0d decoded bytes",
             n_items, n_strings, n_results, n_bytes);
    $display("string endings ok/bad hex/odd/bad utf8/unfinished: %0d %0d %0d %0d %0d",
             status_cnt[STATUS_OK], status_cnt[STATUS_BAD_HEX], status_cnt[STATUS_ODD],
             status_cnt[STATUS_BAD_UTF], status_cnt[STATUS_OPEN]);
    if (n_fail == 0 && folded_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
